>>> hdl/skt_pkg.sv
// Shared types and codes for the sorted key table insert/remove unit.
package skt_pkg;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] entry_handle;
  } in_item_t;

  typedef struct packed {
    logic [7:0] position;
    logic       found;
    logic       table_full;
    logic [8:0] entry_total;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_INSERT,
    UPD_REMOVE,
    UPD_REPLACE
  } upd_kind_e;

  typedef struct packed {
    logic      cmp_en;
    upd_kind_e kind;
  } cell_ctl_t;

endpackage

>>> hdl/skt_cell.sv
// One table slot: holds an entry, compares it with the search key, shifts with its neighbors.
module skt_cell #(
  parameter int KEY_W = 64,
  parameter int LEN_W = 4,
  parameter int HND_W = 32,
  parameter int CNT_W = 9,
  parameter int IDX   = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skt_pkg::cell_ctl_t ctl_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [KEY_W-1:0]  new_key_i,
  input  logic [LEN_W-1:0]  new_len_i,
  input  logic [HND_W-1:0]  new_hnd_i,
  input  logic [KEY_W-1:0]  lo_key_i,
  input  logic [LEN_W-1:0]  lo_len_i,
  input  logic [HND_W-1:0]  lo_hnd_i,
  input  logic              lo_before_i,
  input  logic [KEY_W-1:0]  hi_key_i,
  input  logic [LEN_W-1:0]  hi_len_i,
  input  logic [HND_W-1:0]  hi_hnd_i,
  output logic [KEY_W-1:0]  key_o,
  output logic [LEN_W-1:0]  len_o,
  output logic [HND_W-1:0]  hnd_o,
  output logic              before_o,
  output logic              eq_o
);
  import skt_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [HND_W-1:0] hnd_q, hnd_d;
  logic             before_q, eq_q;
  logic             occ, lt, eq, boundary;

  // Zero-padded keys: ordering is (key, length) lexicographic.
  assign occ = count_i > CNT_W'(IDX);
  assign lt  = {key_q, len_q} < {new_key_i, new_len_i};
  assign eq  = {key_q, len_q} == {new_key_i, new_len_i};
  assign boundary = lo_before_i & ~before_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= 1'b0;
      eq_q     <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      before_q <= occ & lt;
      eq_q     <= occ & eq;
    end
  end

  always_comb begin
    key_d = key_q;
    len_d = len_q;
    hnd_d = hnd_q;
    case (ctl_i.kind)
      UPD_INSERT: begin
        if (!before_q) begin
          if (boundary) begin
            key_d = new_key_i;
            len_d = new_len_i;
            hnd_d = new_hnd_i;
          end else begin
            key_d = lo_key_i;
            len_d = lo_len_i;
            hnd_d = lo_hnd_i;
          end
        end
      end
      UPD_REMOVE: begin
        if (!before_q) begin
          key_d = hi_key_i;
          len_d = hi_len_i;
          hnd_d = hi_hnd_i;
        end
      end
      UPD_REPLACE: begin
        if (eq_q) begin
          hnd_d = new_hnd_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    len_q <= len_d;
    hnd_q <= hnd_d;
  end

  assign key_o    = key_q;
  assign len_o    = len_q;
  assign hnd_o    = hnd_q;
  assign before_o = before_q;
  assign eq_o     = eq_q;

endmodule

>>> hdl/sorted_key_table_insert_remove_unit.sv
// Sorted key table: a row of TABLE_DEPTH cells, each compares and shifts in place.
// The input is registered, compared in the compare state, then the result is loaded in the update state.
// Items do not overlap: the next item waits for the compare-then-shift pass over the cell row.
// A stalled result holds the update stage; the next input is taken as the result is loaded.
// Reset clears the entry count and control state; cell contents stay undefined until written.
module sorted_key_table_insert_remove_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8,
  parameter int HANDLE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  skt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output skt_pkg::out_item_t out_data_o
);
  import skt_pkg::*;

  localparam int KEY_W = KEY_BYTES * 8;
  localparam int LEN_W = $clog2(KEY_BYTES + 1);
  localparam int HND_W = HANDLE_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [KEY_W-1:0] key_q;
  logic [LEN_W-1:0] len_q;
  logic [HND_W-1:0] hnd_q;
  logic             act_q;
  logic [CNT_W-1:0] count_q, count_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q;

  logic             in_xfer, upd_go, cmp_en;
  cell_ctl_t        ctl;

  // input normalization
  logic [3:0]       len_sat;
  logic [KEY_W-1:0] key_norm;
  logic [63:0]      hnd_ext;

  always_comb begin
    len_sat = (in_data_i.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_data_i.key_length;
    key_norm = in_data_i.key_bytes[KEY_W-1:0];
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (4'(b) >= len_sat) begin
        key_norm[KEY_W-1-8*b -: 8] = 8'h00;
      end
    end
    hnd_ext = 64'(in_data_i.entry_handle);
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= key_norm;
      len_q <= len_sat[LEN_W-1:0];
      hnd_q <= hnd_ext[HND_W-1:0];
      act_q <= in_data_i.action;
    end
  end

  // cell row
  logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
  logic [LEN_W-1:0] cell_len [TABLE_DEPTH];
  logic [HND_W-1:0] cell_hnd [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] before_w, eq_w;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lo_key, hi_key;
    logic [LEN_W-1:0] lo_len, hi_len;
    logic [HND_W-1:0] lo_hnd, hi_hnd;
    logic             lo_before;

    if (i == 0) begin : g_first
      assign lo_key    = '0;
      assign lo_len    = '0;
      assign lo_hnd    = '0;
      assign lo_before = 1'b1;
    end else begin : g_mid
      assign lo_key    = cell_key[i-1];
      assign lo_len    = cell_len[i-1];
      assign lo_hnd    = cell_hnd[i-1];
      assign lo_before = before_w[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign hi_key = '0;
      assign hi_len = '0;
      assign hi_hnd = '0;
    end else begin : g_up
      assign hi_key = cell_key[i+1];
      assign hi_len = cell_len[i+1];
      assign hi_hnd = cell_hnd[i+1];
    end

    skt_cell #(
      .KEY_W(KEY_W),
      .LEN_W(LEN_W),
      .HND_W(HND_W),
      .CNT_W(CNT_W),
      .IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .count_i    (count_q),
      .new_key_i  (key_q),
      .new_len_i  (len_q),
      .new_hnd_i  (hnd_q),
      .lo_key_i   (lo_key),
      .lo_len_i   (lo_len),
      .lo_hnd_i   (lo_hnd),
      .lo_before_i(lo_before),
      .hi_key_i   (hi_key),
      .hi_len_i   (hi_len),
      .hi_hnd_i   (hi_hnd),
      .key_o      (cell_key[i]),
      .len_o      (cell_len[i]),
      .hnd_o      (cell_hnd[i]),
      .before_o   (before_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  // position: first cell that does not sort before the key
  logic [IDX_W-1:0] pos_enc, pos;
  logic             any_bnd, hit, is_full;

  always_comb begin
    pos_enc = '0;
    any_bnd = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (((i == 0) ? 1'b1 : before_w[(i == 0) ? 0 : i-1]) && !before_w[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
        any_bnd = 1'b1;
      end
    end
    // every slot sorts before the key: clamp to the last index
    pos     = any_bnd ? pos_enc : IDX_W'(TABLE_DEPTH - 1);
    hit     = |eq_w;
    is_full = count_q == CNT_W'(TABLE_DEPTH);
  end

  // control
  assign upd_go = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
  assign in_xfer = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CMP;
      end
      ST_CMP: state_d = ST_UPD;
      ST_UPD: begin
        if (upd_go) state_d = in_valid_i ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmp_en     = 1'b0;
    ctl.kind   = UPD_NONE;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CMP:  cmp_en = 1'b1;
      ST_UPD: begin
        in_ready_o = upd_go;
        if (upd_go) begin
          if (act_q == ACT_ADD) begin
            if (hit)           ctl.kind = UPD_REPLACE;
            else if (!is_full) ctl.kind = UPD_INSERT;
          end else if (hit) begin
            ctl.kind = UPD_REMOVE;
          end
        end
      end
      default: ;
    endcase
    ctl.cmp_en = cmp_en;
  end

  logic [31:0] pos_ext, cnt_ext;

  always_comb begin
    count_d = count_q;
    case (ctl.kind)
      UPD_INSERT: count_d = count_q + CNT_W'(1);
      UPD_REMOVE: count_d = count_q - CNT_W'(1);
      default: ;
    endcase
    pos_ext = 32'(pos);
    cnt_ext = 32'(count_d);
    out_d.position    = pos_ext[7:0];
    out_d.found       = hit;
    out_d.table_full  = (act_q == ACT_ADD) && !hit && is_full;
    out_d.entry_total = cnt_ext[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (upd_go)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/sorted_key_table_insert_remove_unit_test.sv
// Testbench for the sorted key table insert/remove unit: shadow table predictor with result checks.
module sorted_key_table_insert_remove_unit_test;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BYTES   = 8;
  localparam int HANDLE_BITS = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_START  = 120;
  localparam int HOLD_CYCLES = 80;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  sorted_key_table_insert_remove_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the key table
  logic [63:0] shadow_key [TABLE_DEPTH];
  logic [3:0]  shadow_len [TABLE_DEPTH];
  logic [31:0] shadow_hdl [TABLE_DEPTH];
  int          shadow_count = 0;

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  logic [63:0] issued_keys[$];
  logic [3:0]  issued_lens[$];

  int in_xfers     = 0;
  int out_xfers    = 0;
  int stall_cycles = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int errors       = 0;

  function automatic logic [63:0] byte_mask(int unsigned n);
    if (n == 0) return '0;
    return {64{1'b1}} << (8 * (KEY_BYTES - n));
  endfunction

  // Bytewise over the shorter length, then shorter key first
  function automatic int key_order(logic [63:0] k1, int unsigned l1,
                                   logic [63:0] k2, int unsigned l2);
    logic [63:0] m;
    m = byte_mask((l1 < l2) ? l1 : l2);
    if ((k1 & m) != (k2 & m)) return ((k1 & m) < (k2 & m)) ? -1 : 1;
    if (l1 != l2) return (l1 < l2) ? -1 : 1;
    return 0;
  endfunction

  function automatic out_item_t apply_table_update(in_item_t it);
    int unsigned len;
    logic [63:0] key;
    int          lo, hi, mid, c, slot;
    bit          hit, full;
    out_item_t   r;
    len  = (it.key_length > KEY_BYTES) ? KEY_BYTES : it.key_length;
    key  = it.key_bytes & byte_mask(len);
    lo   = 0;
    hi   = shadow_count;
    hit  = 1'b0;
    full = 1'b0;
    while (hi > lo && !hit) begin
      mid = (lo + hi) >> 1;
      c = key_order(key, len, shadow_key[mid], shadow_len[mid]);
      if (c == 0) begin
        hit = 1'b1;
        lo = mid;
      end else if (c < 0) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    slot = (lo >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : lo;
    if (it.action == ACT_ADD) begin
      if (hit) begin
        shadow_hdl[slot] = it.entry_handle;
      end else if (shadow_count >= TABLE_DEPTH) begin
        full = 1'b1;
      end else begin
        for (int i = shadow_count; i > slot; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_len[i] = shadow_len[i-1];
          shadow_hdl[i] = shadow_hdl[i-1];
        end
        shadow_key[slot] = key;
        shadow_len[slot] = 4'(len);
        shadow_hdl[slot] = it.entry_handle;
        shadow_count++;
      end
    end else if (hit) begin
      for (int i = slot; i + 1 < shadow_count; i++) begin
        shadow_key[i] = shadow_key[i+1];
        shadow_len[i] = shadow_len[i+1];
        shadow_hdl[i] = shadow_hdl[i+1];
      end
      shadow_count--;
    end
    r.position    = 8'(slot);
    r.found       = hit;
    r.table_full  = full;
    r.entry_total = 9'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", out_xfers, msg);
    errors++;
  endtask

  task automatic queue_item(logic act, logic [63:0] key, logic [3:0] len, logic [31:0] hdl);
    in_item_t it;
    it.action       = act;
    it.key_bytes    = key;
    it.key_length   = len;
    it.entry_handle = hdl;
    pending_items.push_back(it);
    if (act == ACT_ADD) begin
      issued_keys.push_back(key);
      issued_lens.push_back(len);
    end
  endtask

  // Fresh key: fully random, or built from a few byte values so prefixes collide
  task automatic fresh_key(output logic [63:0] key, output logic [3:0] len);
    logic [7:0] letters [6];
    letters = '{8'h00, 8'h01, 8'h41, 8'h7F, 8'h80, 8'hFF};
    len = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if ($urandom_range(1) == 1) begin
      key = {$urandom, $urandom};
    end else begin
      for (int b = 0; b < 8; b++) key[8*b +: 8] = letters[$urandom_range(5)];
    end
  endtask

  // Earlier key with new padding garbage and, at full length, an aliased length
  task automatic reused_key(output logic [63:0] key, output logic [3:0] len);
    int          idx;
    logic [63:0] m;
    idx = $urandom_range(issued_keys.size() - 1);
    len = issued_lens[idx];
    m   = byte_mask((len > KEY_BYTES) ? KEY_BYTES : len);
    key = (issued_keys[idx] & m) | ({$urandom, $urandom} & ~m);
    if (len >= KEY_BYTES) len = 4'($urandom_range(KEY_BYTES, 15));
  endtask

  task automatic random_items(int count, int remove_pct, int add_reuse_pct,
                              int remove_reuse_pct);
    logic [63:0] key;
    logic [3:0]  len;
    logic        act;
    for (int n = 0; n < count; n++) begin
      act = ($urandom_range(99) < remove_pct) ? ACT_REMOVE : ACT_ADD;
      if (issued_keys.size() > 0 && $urandom_range(99) <
          ((act == ACT_ADD) ? add_reuse_pct : remove_reuse_pct))
        reused_key(key, len);
      else
        fresh_key(key, len);
      queue_item(act, key, len, $urandom);
    end
  endtask

  // Sender: one item per transfer, random gaps outside the no-idle window
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_items.size() > 0 &&
          !((in_xfers < 300 || in_xfers >= 450) && $urandom_range(99) < 33)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!hold_done && in_xfers >= HOLD_START) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !((out_xfers < 350 || out_xfers >= 500) && $urandom_range(99) < 33);
    end
  end

  // Monitor: predict on input transfers, check on output transfers, watchdog
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_xfers <= out_xfers + 1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %p", out_data_o));
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_data_o.position, want.position));
          if (out_data_o.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b",
                                      out_data_o.found, want.found));
          if (out_data_o.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %0b, expected %0b",
                                      out_data_o.table_full, want.table_full));
          if (out_data_o.entry_total !== want.entry_total)
            report_mismatch($sformatf("entry_total %0d, expected %0d",
                                      out_data_o.entry_total, want.entry_total));
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_xfers <= in_xfers + 1;
        expected_results.push_back(apply_table_update(in_data_i));
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    // directed: empty table, empty key, padding, saturated length, byte order, removes
    queue_item(ACT_REMOVE, 64'h4100_0000_0000_0000, 4'd1, 32'h0);
    queue_item(ACT_ADD,    64'hDEAD_BEEF_0123_4567, 4'd0, 32'h0000_0000);
    queue_item(ACT_ADD,    64'h41FF_FFFF_FFFF_FFFF, 4'd1, 32'hFFFF_FFFF);
    queue_item(ACT_ADD,    64'h4112_3456_789A_BCDE, 4'd1, 32'h1234_5678);
    queue_item(ACT_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hAAAA_5555);
    queue_item(ACT_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h5555_AAAA);
    queue_item(ACT_ADD,    64'h0000_0000_0000_0000, 4'd8, 32'h0000_0001);
    queue_item(ACT_ADD,    64'h4100_00FF_FFFF_FFFF, 4'd3, 32'h0000_0003);
    queue_item(ACT_ADD,    64'h8000_0000_0000_0000, 4'd1, 32'h8000_0000);
    queue_item(ACT_ADD,    64'h7F00_0000_0000_0000, 4'd1, 32'h7FFF_FFFF);
    queue_item(ACT_ADD,    64'h7FFF_0000_0000_0000, 4'd2, 32'h0F0F_0F0F);
    queue_item(ACT_ADD,    64'h0100_0000_0000_0001, 4'd9, 32'hF0F0_F0F0);
    queue_item(ACT_REMOVE, 64'h41AB_CDEF_0000_0000, 4'd2, 32'h0);
    queue_item(ACT_REMOVE, 64'h7F00_0000_0000_0000, 4'd1, 32'h0);
    queue_item(ACT_REMOVE, 64'h0000_0000_0000_0000, 4'd0, 32'h0);
    queue_item(ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'h0);
    queue_item(ACT_REMOVE, 64'h41FF_FFFF_FFFF_FFFF, 4'd1, 32'h0);
    queue_item(ACT_REMOVE, 64'h4100_0000_0000_0000, 4'd1, 32'h0);
    queue_item(ACT_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
    queue_item(ACT_REMOVE, 64'h0000_0000_0000_0000, 4'd8, 32'h0);
    // mostly fresh inserts until the table overflows, then churn
    random_items(400, 5, 15, 70);
    random_items(300, 55, 40, 80);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
